// ----- rtl/core/md5_pkg.sv -----
// Shared types, constants and tables for the MD5 digest engine.
`default_nettype none

package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Byte positions in a 64-byte block; 56 is where the length field starts.
  localparam int unsigned POS_W     = 7;
  localparam logic [6:0]  POS_LEN   = 7'd56;
  localparam logic [5:0]  POS_LASTB = 6'd63;
  localparam logic [5:0]  RND_LAST  = 6'd63;
  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [3:0]  WORD_LEN_LO = 4'd14;
  localparam logic [3:0]  WORD_LEN_HI = 4'd15;
  localparam int unsigned CNT_W     = 61;  // byte count; bit length is count * 8

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_LENHI,
    ST_ROUND,
    ST_FOLD
  } md5_state_e;

  // What follows the compression that is running.
  typedef enum logic [1:0] {
    PH_DATA,
    PH_WRAP,
    PH_FINAL
  } md5_phase_e;

  function automatic logic [31:0] md5_k(input logic [5:0] n);
    logic [31:0] k;
    case (n)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] n);
    logic [4:0] s;
    case ({n[5:4], n[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word index used by round n.
  function automatic logic [3:0] md5_gidx(input logic [5:0] n);
    logic [3:0] nl;
    logic [3:0] g;
    nl = n[3:0];
    case (n[5:4])
      2'd0:    g = nl;
      2'd1:    g = 4'(nl * 4'd5 + 4'd1);
      2'd2:    g = 4'(nl * 4'd3 + 4'd5);
      default: g = 4'(nl * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_bswap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/md5_round.sv -----
// One MD5 round: the shared arithmetic unit stepped 64 times per block.
`default_nettype none

module md5_round
  import md5_pkg::*;
(
  input  md5_abcd_t   state_i,
  input  logic [31:0] word_i,
  input  logic [5:0]  rnd_i,
  output md5_abcd_t   state_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;

  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (state_i.b & state_i.c) | (~state_i.b & state_i.d);
      2'd1:    f = (state_i.d & state_i.b) | (~state_i.d & state_i.c);
      2'd2:    f = state_i.b ^ state_i.c ^ state_i.d;
      default: f = state_i.c ^ (state_i.b | ~state_i.d);
    endcase
    sum      = state_i.a + f + word_i + md5_k(rnd_i);
    rot_wide = {sum, sum} << md5_rot(rnd_i);
    state_o.a = state_i.d;
    state_o.b = state_i.b + rot_wide[63:32];
    state_o.c = state_i.b;
    state_o.d = state_i.c;
  end

endmodule

`default_nettype wire

// ----- rtl/core/md5_digest_engine_core.sv -----
// MD5 digest engine: byte stream in, 128-bit digest out as two 64-bit halves.
`default_nettype none

// Takes a message one byte per request on the slave stream (tdata = byte,
// tuser = byte present, tlast = end of message; a tlast request with tuser low
// ends the message without adding a byte, so it also encodes the empty
// message). Bytes are packed into a 16-word block buffer; each full block is
// compressed by a single round unit, one round per cycle. Timing: a byte is
// taken every cycle while the block fills; the 64th byte of a block starts the
// rounds and a fold step, and no byte is taken until they are done. At end of
// message the 0x80 mark and the zero bytes up to byte 55 are written one per
// cycle, and the sequencer then moves on to the length. When the tail leaves
// no room for the length, the zeros run to byte 63, an extra compression
// follows, and bytes 0..55 of the next block are zeroed after it. Then the
// length words are written, low word first, and the last block is compressed
// before the first digest half is valid. The digest then leaves on the master
// stream as two requests: bytes 0..7 first (byte 0 in the top bits, tlast
// low), then bytes 8..15 with tlast high. The digest sits in its own output
// register, so the next message may start while it waits; only the next
// digest load waits for it to drain. Chain values and the length counter
// return to the MD5 IV and zero after every digest.
module md5_digest_engine_core
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] digest_half
  output logic        m_axis_tlast_o    // final_half
);

  // Sequencer state
  md5_state_e       st_q, st_d;
  md5_phase_e       ph_q, ph_d;
  logic [5:0]       rnd_q, rnd_d;
  logic [POS_W-1:0] pos_q, pos_d;      // padding byte position, 0..64
  logic             wrap_q, wrap_d;    // padding spills into an extra block
  logic             fin_q, fin_d;      // last request seen, padding still due
  logic [CNT_W-1:0] cnt_q, cnt_d;      // message byte count

  md5_abcd_t        chain_q, chain_d;
  md5_abcd_t        work_q, work_d;
  md5_abcd_t        round_out;
  md5_abcd_t        chain_sum;

  // Block buffer, byte-lane write port
  logic [31:0]      blk_q [16];
  logic             bw_en;
  logic [3:0]       bw_idx;
  logic [3:0]       bw_mask;
  logic [31:0]      bw_data;
  logic [31:0]      blk_rd_q;

  // Output register
  logic             out_v_q;
  logic             out_hi_q;
  logic [127:0]     dig_q;
  logic             dig_load;

  logic             in_acc;
  logic             out_acc;

  assign s_axis_tready_o = (st_q == ST_IDLE);

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = out_v_q && m_axis_tready_i;

  md5_round u_round (
    .state_i (work_q),
    .word_i  (blk_rd_q),
    .rnd_i   (rnd_q),
    .state_o (round_out)
  );

  always_comb begin
    chain_sum.a = chain_q.a + work_q.a;
    chain_sum.b = chain_q.b + work_q.b;
    chain_sum.c = chain_q.c + work_q.c;
    chain_sum.d = chain_q.d + work_q.d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ph_q    <= PH_DATA;
      rnd_q   <= '0;
      pos_q   <= '0;
      wrap_q  <= 1'b0;
      fin_q   <= 1'b0;
      cnt_q   <= '0;
      chain_q <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      rnd_q   <= rnd_d;
      pos_q   <= pos_d;
      wrap_q  <= wrap_d;
      fin_q   <= fin_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
    end
  end

  // Working variables are payload: loaded before every compression.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_comb begin
    st_d     = st_q;
    ph_d     = ph_q;
    rnd_d    = rnd_q;
    pos_d    = pos_q;
    wrap_d   = wrap_q;
    fin_d    = fin_q;
    cnt_d    = cnt_q;
    chain_d  = chain_q;
    work_d   = work_q;
    bw_en    = 1'b0;
    bw_idx   = '0;
    bw_mask  = '0;
    bw_data  = '0;
    dig_load = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            bw_en   = 1'b1;
            bw_idx  = cnt_q[5:2];
            bw_mask = 4'b0001 << cnt_q[1:0];
            bw_data = {4{s_axis_tdata_i}};
            cnt_d   = cnt_q + 1'b1;
            if (cnt_q[5:0] == POS_LASTB) begin
              // full block: compress, padding follows if this was the end
              fin_d  = s_axis_tlast_i;
              ph_d   = PH_DATA;
              work_d = chain_q;
              st_d   = ST_ROUND;
            end else if (s_axis_tlast_i) begin
              st_d = ST_PAD80;
            end
          end else if (s_axis_tlast_i) begin
            st_d = ST_PAD80;
          end
        end
      end

      ST_PAD80: begin
        bw_en   = 1'b1;
        bw_idx  = cnt_q[5:2];
        bw_mask = 4'b0001 << cnt_q[1:0];
        bw_data = {4{PAD_BYTE}};
        pos_d   = {1'b0, cnt_q[5:0]} + 1'b1;
        wrap_d  = pos_d > POS_LEN;
        fin_d   = 1'b0;
        st_d    = ST_PADZ;
      end

      ST_PADZ: begin
        if (pos_q[POS_W-1]) begin
          // tail block full of padding, length goes in the next one
          ph_d   = PH_WRAP;
          work_d = chain_q;
          st_d   = ST_ROUND;
        end else if (pos_q == POS_LEN && !wrap_q) begin
          st_d = ST_LEN;
        end else begin
          bw_en   = 1'b1;
          bw_idx  = pos_q[5:2];
          bw_mask = 4'b0001 << pos_q[1:0];
          bw_data = '0;
          pos_d   = pos_q + 1'b1;
        end
      end

      ST_LEN: begin
        bw_en   = 1'b1;
        bw_idx  = WORD_LEN_LO;
        bw_mask = 4'b1111;
        bw_data = {cnt_q[28:0], 3'b000};
        st_d    = ST_LENHI;
      end

      ST_LENHI: begin
        bw_en   = 1'b1;
        bw_idx  = WORD_LEN_HI;
        bw_mask = 4'b1111;
        bw_data = cnt_q[60:29];
        ph_d    = PH_FINAL;
        work_d  = chain_q;
        st_d    = ST_ROUND;
      end

      ST_ROUND: begin
        work_d = round_out;
        rnd_d  = rnd_q + 1'b1;
        if (rnd_q == RND_LAST) begin
          st_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        case (ph_q)
          PH_FINAL: begin
            // wait for the previous digest to drain
            if (!out_v_q) begin
              dig_load = 1'b1;
              chain_d  = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
              cnt_d    = '0;
              st_d     = ST_IDLE;
            end
          end
          PH_WRAP: begin
            chain_d = chain_sum;
            pos_d   = '0;
            wrap_d  = 1'b0;
            st_d    = ST_PADZ;
          end
          default: begin
            chain_d = chain_sum;
            st_d    = fin_q ? ST_PAD80 : ST_IDLE;
          end
        endcase
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Message word for the next round is registered from the next round index.
  always_ff @(posedge clk_i) begin
    if (bw_en) begin
      for (int l = 0; l < 4; l++) begin
        if (bw_mask[l]) begin
          blk_q[bw_idx][8*l +: 8] <= bw_data[8*l +: 8];
        end
      end
    end
    blk_rd_q <= blk_q[md5_gidx(rnd_d)];
  end

  // Digest output: high half first, then low half with tlast.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      out_hi_q <= 1'b0;
    end else if (dig_load) begin
      out_v_q  <= 1'b1;
      out_hi_q <= 1'b0;
    end else if (out_acc) begin
      out_v_q  <= !out_hi_q;
      out_hi_q <= !out_hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_load) begin
      dig_q <= {md5_bswap(chain_sum.a), md5_bswap(chain_sum.b),
                md5_bswap(chain_sum.c), md5_bswap(chain_sum.d)};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_hi_q;
  assign m_axis_tdata_o  = out_hi_q ? dig_q[63:0] : dig_q[127:64];

`ifndef SYNTHESIS
  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_ROUND) |-> (rnd_q == '0))
    else $error("round counter not parked outside compression");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PADZ) |-> (pos_q <= 7'd64))
    else $error("padding position out of range");

  a_dig_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_load |=> (m_axis_tvalid_o && !m_axis_tlast_o && cnt_q == '0))
    else $error("digest load did not start a fresh output pair");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_load |-> !out_v_q)
    else $error("digest loaded over a pending one");

  a_len_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LEN) |-> (pos_q == POS_LEN && !wrap_q))
    else $error("length written at wrong position");
`endif

endmodule

`default_nettype wire
